// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, a, b)
`define ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ----- src/lgi_pkg.sv -----
// ---------------------------------------------------------------------------
// lgi_pkg
// Widths, command and status types and helpers of the Lagrange gamma unit.
// ---------------------------------------------------------------------------
`default_nettype none

package lgi_pkg;

    localparam int LEVEL_W   = 15;
    localparam int COLOR_W   = 8;
    localparam int FRAC_BITS = 24;
    localparam int DIFF_W    = 16;
    localparam int QUOT_W    = 39;
    localparam int REM_W     = 15;
    localparam int WMAG_W    = 47;
    localparam int CHUNK_W   = 13;
    localparam int MUL_STEPS = 3;
    localparam int ACC_W     = 86;
    localparam int PP_W      = 60;
    localparam int CPROD_W   = 55;
    localparam int SUM_W     = 64;
    localparam int STEP_W    = 6;
    localparam int DIV_STEPS = 39;
    localparam int COLOR_MAX = 255;

    typedef struct packed {
        logic       wr_en;
        logic       init_w;
        logic       div_start;
        logic       div_step;
        logic       mul_step;
        logic [1:0] mul_sel;
        logic       w_update;
        logic       acc;
        logic       set_degen;
        logic       out_load;
    } lgi_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic out_busy;
    } lgi_status_t;

    // Integer part of a Q.24 colour sum, floored at zero and clamped to 255.
    function automatic logic [COLOR_W-1:0] finish_sum(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-FRAC_BITS-1:0] v;
        v = s[SUM_W-1:FRAC_BITS];
        if (s <= 0)
            return '0;
        else if (v > (SUM_W-FRAC_BITS)'(COLOR_MAX))
            return COLOR_W'(COLOR_MAX);
        else
            return v[COLOR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/lgi_ctrl.sv -----
// ---------------------------------------------------------------------------
// lgi_ctrl
// Sequencer: loads nodes, then walks node pairs through divide, multiply and
// accumulate steps in the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module lgi_ctrl #(
    parameter int NODE_COUNT = 9
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tlast,
    output logic                                s_tready,
    input  wire lgi_pkg::lgi_status_t           status,
    output lgi_pkg::lgi_cmd_t                   cmd,
    output logic [$clog2(NODE_COUNT)-1:0]       wr_addr,
    output logic [$clog2(NODE_COUNT)-1:0]       rd_t,
    output logic [$clog2(NODE_COUNT)-1:0]       rd_k
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_COUNT + 1);

    typedef enum logic [8:0] {
        ST_LOAD    = 9'b000000001,
        ST_START_T = 9'b000000010,
        ST_READ    = 9'b000000100,
        ST_CHECK   = 9'b000001000,
        ST_DIV     = 9'b000010000,
        ST_MUL     = 9'b000100000,
        ST_WUPD    = 9'b001000000,
        ST_ACC     = 9'b010000000,
        ST_FINISH  = 9'b100000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic [IDX_W-1:0]            t_reg, t_next;
    logic [IDX_W-1:0]            k_reg, k_next;
    logic [lgi_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        last_t, last_k;

    assign last_t  = (CNT_W'(t_reg) == n_reg - CNT_W'(1));
    assign last_k  = (CNT_W'(k_reg) == n_reg - CNT_W'(1));
    assign wr_addr = count_reg[IDX_W-1:0];
    assign rd_t    = t_reg;
    assign rd_k    = k_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        n_next     = n_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (count_reg < CNT_W'(NODE_COUNT))
                    begin
                        cmd.wr_en  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast)
                    begin
                        n_next     = (count_reg < CNT_W'(NODE_COUNT)) ?
                                     count_reg + CNT_W'(1) : count_reg;
                        count_next = '0;
                        t_next     = '0;
                        state_next = ST_START_T;
                    end
                end
            end
            ST_START_T:
            begin
                cmd.init_w = 1'b1;
                k_next     = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (k_reg == t_reg)
                begin
                    if (last_k)
                        state_next = ST_ACC;
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
                else if (status.den_zero)
                begin
                    cmd.set_degen = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    step_next     = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == lgi_pkg::STEP_W'(lgi_pkg::DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_MUL;
                end
                else
                    step_next = step_reg + lgi_pkg::STEP_W'(1);
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = step_reg[1:0];
                if (step_reg == lgi_pkg::STEP_W'(lgi_pkg::MUL_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_WUPD;
                end
                else
                    step_next = step_reg + lgi_pkg::STEP_W'(1);
            end
            ST_WUPD:
            begin
                cmd.w_update = 1'b1;
                if (last_k)
                    state_next = ST_ACC;
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (last_t)
                    state_next = ST_FINISH;
                else
                begin
                    t_next     = t_reg + IDX_W'(1);
                    state_next = ST_START_T;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            n_reg     <= '0;
            t_reg     <= '0;
            k_reg     <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            t_reg     <= t_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/lgi_datapath.sv -----
// ---------------------------------------------------------------------------
// lgi_datapath
// Node stores, radix-2 divider, chunked weight multiplier, colour sums and
// the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module lgi_datapath #(
    parameter int NODE_COUNT = 9
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [lgi_pkg::LEVEL_W-1:0]         picture_level,
    input  wire logic [lgi_pkg::LEVEL_W-1:0]         node_level,
    input  wire logic [lgi_pkg::COLOR_W-1:0]         red_value,
    input  wire logic [lgi_pkg::COLOR_W-1:0]         green_value,
    input  wire logic [lgi_pkg::COLOR_W-1:0]         blue_value,
    input  wire lgi_pkg::lgi_cmd_t                   cmd,
    input  wire logic [$clog2(NODE_COUNT)-1:0]       wr_addr,
    input  wire logic [$clog2(NODE_COUNT)-1:0]       rd_t,
    input  wire logic [$clog2(NODE_COUNT)-1:0]       rd_k,
    output lgi_pkg::lgi_status_t                     status,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic [lgi_pkg::COLOR_W-1:0]              red_out,
    output logic [lgi_pkg::COLOR_W-1:0]              green_out,
    output logic [lgi_pkg::COLOR_W-1:0]              blue_out,
    output logic                                     degenerate
);

    localparam int LW = lgi_pkg::LEVEL_W;
    localparam int CW = lgi_pkg::COLOR_W;

    logic [LW-1:0]                   level_mem [NODE_COUNT];
    logic [3*CW-1:0]                 color_mem [NODE_COUNT];
    logic [LW-1:0]                   lvl_t_q, lvl_k_q;
    logic [3*CW-1:0]                 color_q;

    logic signed [lgi_pkg::DIFF_W-1:0] num, den;
    logic [lgi_pkg::DIFF_W-1:0]      num_mag, den_mag;

    logic [lgi_pkg::QUOT_W-1:0]      dvd_reg;
    logic [lgi_pkg::REM_W-1:0]       rem_reg;
    logic [lgi_pkg::REM_W-1:0]       dvs_reg;
    logic                            f_neg_reg;
    logic [lgi_pkg::REM_W:0]         div_trial, div_sub;
    logic                            div_ge;

    logic [lgi_pkg::WMAG_W-1:0]      w_mag_reg;
    logic                            w_neg_reg;
    logic [lgi_pkg::ACC_W-1:0]       acc_reg;
    logic [lgi_pkg::CHUNK_W-1:0]     chunk;
    logic [lgi_pkg::PP_W-1:0]        pp;
    logic [lgi_pkg::ACC_W-1:0]       pp_shift;

    logic [lgi_pkg::CPROD_W-1:0]     cp_r, cp_g, cp_b;
    logic signed [lgi_pkg::SUM_W-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic                            degen_reg;
    logic                            out_valid_reg;

    // Node stores: one write port; two registered level reads, one colour read.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            level_mem[wr_addr] <= node_level;
            color_mem[wr_addr] <= {red_value, green_value, blue_value};
        end
        lvl_t_q <= level_mem[rd_t];
        lvl_k_q <= level_mem[rd_k];
        color_q <= color_mem[rd_t];
    end

    assign num     = $signed({1'b0, picture_level}) - $signed({1'b0, lvl_k_q});
    assign den     = $signed({1'b0, lvl_t_q}) - $signed({1'b0, lvl_k_q});
    assign num_mag = num[lgi_pkg::DIFF_W-1] ? lgi_pkg::DIFF_W'(-num) : lgi_pkg::DIFF_W'(num);
    assign den_mag = den[lgi_pkg::DIFF_W-1] ? lgi_pkg::DIFF_W'(-den) : lgi_pkg::DIFF_W'(den);

    assign div_trial = {rem_reg, dvd_reg[lgi_pkg::QUOT_W-1]};
    assign div_ge    = (div_trial >= {1'b0, dvs_reg});
    assign div_sub   = div_trial - {1'b0, dvs_reg};

    always_comb
    begin
        case (cmd.mul_sel)
            2'd0:    chunk = dvd_reg[lgi_pkg::CHUNK_W-1:0];
            2'd1:    chunk = dvd_reg[2*lgi_pkg::CHUNK_W-1:lgi_pkg::CHUNK_W];
            2'd2:    chunk = dvd_reg[3*lgi_pkg::CHUNK_W-1:2*lgi_pkg::CHUNK_W];
            default: chunk = '0;
        endcase
    end

    assign pp = lgi_pkg::PP_W'(w_mag_reg) * lgi_pkg::PP_W'(chunk);

    always_comb
    begin
        case (cmd.mul_sel)
            2'd1:    pp_shift = lgi_pkg::ACC_W'(pp) << lgi_pkg::CHUNK_W;
            2'd2:    pp_shift = lgi_pkg::ACC_W'(pp) << (2 * lgi_pkg::CHUNK_W);
            default: pp_shift = lgi_pkg::ACC_W'(pp);
        endcase
    end

    assign cp_r = lgi_pkg::CPROD_W'(color_q[3*CW-1:2*CW]) * lgi_pkg::CPROD_W'(w_mag_reg);
    assign cp_g = lgi_pkg::CPROD_W'(color_q[2*CW-1:CW]) * lgi_pkg::CPROD_W'(w_mag_reg);
    assign cp_b = lgi_pkg::CPROD_W'(color_q[CW-1:0]) * lgi_pkg::CPROD_W'(w_mag_reg);

    // Divider and weight multiplier; the quotient is left in dvd_reg.
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg   <= {num_mag[lgi_pkg::REM_W-1:0], {lgi_pkg::FRAC_BITS{1'b0}}};
            dvs_reg   <= den_mag[lgi_pkg::REM_W-1:0];
            rem_reg   <= '0;
            f_neg_reg <= num[lgi_pkg::DIFF_W-1] ^ den[lgi_pkg::DIFF_W-1];
            acc_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_sub[lgi_pkg::REM_W-1:0] : div_trial[lgi_pkg::REM_W-1:0];
            dvd_reg <= {dvd_reg[lgi_pkg::QUOT_W-2:0], div_ge};
        end
        else if (cmd.mul_step)
            acc_reg <= acc_reg + pp_shift;

        if (cmd.init_w)
        begin
            w_mag_reg <= lgi_pkg::WMAG_W'(1) << lgi_pkg::FRAC_BITS;
            w_neg_reg <= 1'b0;
        end
        else if (cmd.w_update)
        begin
            // A product at or above 2^63 saturates; below it the shifted value fits.
            w_mag_reg <= (|acc_reg[lgi_pkg::ACC_W-1:63]) ? {lgi_pkg::WMAG_W{1'b1}} :
                         acc_reg[lgi_pkg::FRAC_BITS+lgi_pkg::WMAG_W-1:lgi_pkg::FRAC_BITS];
            w_neg_reg <= w_neg_reg ^ f_neg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            red_out    <= degen_reg ? '0 : lgi_pkg::finish_sum(sum_r_reg);
            green_out  <= degen_reg ? '0 : lgi_pkg::finish_sum(sum_g_reg);
            blue_out   <= degen_reg ? '0 : lgi_pkg::finish_sum(sum_b_reg);
            degenerate <= degen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_r_reg     <= '0;
            sum_g_reg     <= '0;
            sum_b_reg     <= '0;
            degen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                sum_r_reg <= '0;
                sum_g_reg <= '0;
                sum_b_reg <= '0;
                degen_reg <= 1'b0;
            end
            else
            begin
                if (cmd.acc)
                begin
                    if (w_neg_reg)
                    begin
                        sum_r_reg <= sum_r_reg - lgi_pkg::SUM_W'(cp_r);
                        sum_g_reg <= sum_g_reg - lgi_pkg::SUM_W'(cp_g);
                        sum_b_reg <= sum_b_reg - lgi_pkg::SUM_W'(cp_b);
                    end
                    else
                    begin
                        sum_r_reg <= sum_r_reg + lgi_pkg::SUM_W'(cp_r);
                        sum_g_reg <= sum_g_reg + lgi_pkg::SUM_W'(cp_g);
                        sum_b_reg <= sum_b_reg + lgi_pkg::SUM_W'(cp_b);
                    end
                end
                if (cmd.set_degen)
                    degen_reg <= 1'b1;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign status.den_zero = (lvl_t_q == lvl_k_q);
    assign status.out_busy = out_valid_reg & ~m_tready;

endmodule

`default_nettype wire

// ----- src/lagrange_gamma_interp_unit.sv -----
// ---------------------------------------------------------------------------
// lagrange_gamma_interp_unit
// Lagrange interpolation of red, green and blue table values at a target
// picture level over a set of calibration nodes.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake                 | content
//  apb      | in  | psel/penable/pwrite       | picture_level at address 0
//  s_*      | in  | s_tvalid/s_tready         | one calibration node, tlast ends a set
//  m_*      | out | m_tvalid/m_tready         | interpolated colour triple, tuser flag
//
//  s_tready stays high while loading, so a node that is not last is taken as
//  soon as it is valid. After the last node of a set of n nodes, each of the
//  n*(n-1) factors goes through read, compare, radix-2 divide, multiply and
//  weight update; each node adds a start, a self check and an accumulate.
//  A degenerate set ends at the first pair of equal levels found.
//  The result sits in an output register; a stalled result only holds the
//  sequencer once the next set is finished. Reset clears all control state.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lagrange_gamma_interp_unit #(
    parameter int NODE_COUNT = 9
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // node_level[14:0], red_value[22:15], green_value[30:23], blue_value[38:31]
    input  wire logic [39:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic      [23:0] m_tdata,
    // degenerate[0]
    output logic             m_tuser
);

    localparam int IDX_W = $clog2(NODE_COUNT);

    logic [lgi_pkg::LEVEL_W-1:0] picture_level_reg;
    lgi_pkg::lgi_cmd_t           cmd;
    lgi_pkg::lgi_status_t        status;
    logic [IDX_W-1:0]            wr_addr, rd_t, rd_k;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {17'd0, picture_level_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            picture_level_reg <= '0;
        else if (cfg_wr)
            picture_level_reg <= pwdata[lgi_pkg::LEVEL_W-1:0];
    end

    lgi_ctrl #(
        .NODE_COUNT (NODE_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_t     (rd_t),
        .rd_k     (rd_k)
    );

    lgi_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .picture_level (picture_level_reg),
        .node_level    (s_tdata[14:0]),
        .red_value     (s_tdata[22:15]),
        .green_value   (s_tdata[30:23]),
        .blue_value    (s_tdata[38:31]),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .rd_t          (rd_t),
        .rd_k          (rd_k),
        .status        (status),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .red_out       (m_tdata[7:0]),
        .green_out     (m_tdata[15:8]),
        .blue_out      (m_tdata[23:16]),
        .degenerate    (m_tuser)
    );

    // A pending result is never overwritten, and the divider never sees a zero divisor.
    `ASSERT_IMPLIES(a_no_overwrite, cmd.out_load, !(m_tvalid && !m_tready))
    `ASSERT_IMPLIES(a_no_zero_div, cmd.div_start, !status.den_zero)
    `ASSERT_NEXT(a_load_shows, cmd.out_load, m_tvalid)
    `ASSERT_IMPLIES(a_idle_only_ready, s_tready, !cmd.div_step && !cmd.mul_step && !cmd.acc)

endmodule

`default_nettype wire
